/* rtl/rrht_pkg.sv */
`default_nettype none
package rrht_pkg;

  localparam int CAPACITY   = 256;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int ENT_W      = SLOT_W + 1;
  localparam int KEY_W      = 32;
  localparam int COUNT_BITS = 16;
  localparam int LIMIT_W    = 9;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int ROW_W      = KEY_W + COUNT_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET = LIMIT_W'(128);

  // Operation kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UNLOAD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT    = 2'd3;

  // Datapath commands issued by the controller.
  localparam int CMD_W = 4;
  localparam logic [CMD_W-1:0] CMD_NOP       = 4'd0;
  localparam logic [CMD_W-1:0] CMD_START     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_READ      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_FIND_NEXT = 4'd3;
  localparam logic [CMD_W-1:0] CMD_FOUND     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_MISS      = 4'd5;
  localparam logic [CMD_W-1:0] CMD_INS_BEGIN = 4'd6;
  localparam logic [CMD_W-1:0] CMD_INS_STEP  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_INS_PLACE = 4'd8;
  localparam logic [CMD_W-1:0] CMD_REM_BEGIN = 4'd9;
  localparam logic [CMD_W-1:0] CMD_REM_SHIFT = 4'd10;
  localparam logic [CMD_W-1:0] CMD_REM_END   = 4'd11;
  localparam logic [CMD_W-1:0] CMD_MISC      = 4'd12;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              occ;        // probed slot is occupied
    logic              key_eq;     // probed slot holds the key
    logic              dist0;      // probed entry sits in its home slot
    logic              find_last;  // last probe of a lookup
    logic              rem_last;   // last shift of a removal
    logic              room;       // a new id may be inserted
  } sts_t;

endpackage
`default_nettype wire

/* rtl/rrht_ram.sv */
`default_nettype none
module rrht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/rrht_ctrl.sv */
`default_nettype none
module rrht_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rrht_pkg::KIND_W-1:0] kind_i,
  input  wire rrht_pkg::sts_t              sts_i,
  output      logic [rrht_pkg::CMD_W-1:0]  cmd_o,
  output      logic                        busy_o
);
  import rrht_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FRD  = 4'd1;
  localparam logic [3:0] S_FCHK = 4'd2;
  localparam logic [3:0] S_IRD  = 4'd3;
  localparam logic [3:0] S_ICHK = 4'd4;
  localparam logic [3:0] S_RRD  = 4'd5;
  localparam logic [3:0] S_RCHK = 4'd6;
  localparam logic [3:0] S_REND = 4'd7;
  localparam logic [3:0] S_MISC = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = CMD_START;
          state_d = (kind_i <= KIND_REMOVE) ? S_FRD : S_MISC;
        end
      end
      S_FRD: begin
        cmd_o   = CMD_READ;
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (sts_i.occ && sts_i.key_eq) begin
          if (sts_i.kind == KIND_REMOVE) begin
            cmd_o   = CMD_REM_BEGIN;
            state_d = S_RRD;
          end else begin
            cmd_o   = CMD_FOUND;
            state_d = S_IDLE;
          end
        end else if (!sts_i.occ || sts_i.find_last) begin
          if (sts_i.kind == KIND_LOAD && sts_i.room) begin
            cmd_o   = CMD_INS_BEGIN;
            state_d = S_IRD;
          end else begin
            cmd_o   = CMD_MISS;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o   = CMD_FIND_NEXT;
          state_d = S_FRD;
        end
      end
      S_IRD: begin
        cmd_o   = CMD_READ;
        state_d = S_ICHK;
      end
      S_ICHK: begin
        if (!sts_i.occ) begin
          cmd_o   = CMD_INS_PLACE;
          state_d = S_IDLE;
        end else begin
          cmd_o   = CMD_INS_STEP;
          state_d = S_IRD;
        end
      end
      S_RRD: begin
        cmd_o   = CMD_READ;
        state_d = S_RCHK;
      end
      S_RCHK: begin
        if (!sts_i.occ || sts_i.dist0) begin
          cmd_o   = CMD_REM_END;
          state_d = S_IDLE;
        end else begin
          cmd_o   = CMD_REM_SHIFT;
          state_d = sts_i.rem_last ? S_REND : S_RRD;
        end
      end
      S_REND: begin
        cmd_o   = CMD_REM_END;
        state_d = S_IDLE;
      end
      S_MISC: begin
        cmd_o   = CMD_MISC;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

/* rtl/rrht_dp.sv */
`default_nettype none
module rrht_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [rrht_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [rrht_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [rrht_pkg::KEY_W-1:0]    key_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [rrht_pkg::LIMIT_W-1:0]  cfg_data_i,
  output      rrht_pkg::sts_t                sts_o,
  output      logic                          done_o,
  output      logic [rrht_pkg::STATUS_W-1:0] status_o,
  output      logic [rrht_pkg::SLOT_W-1:0]   slot_o,
  output      logic                          edge_res_o,
  output      logic [rrht_pkg::ENT_W-1:0]    entries_o
);
  import rrht_pkg::*;

  logic [KIND_W-1:0]     kind_q;
  logic [KEY_W-1:0]      key_q;
  logic [SLOT_W-1:0]     probe_q, hole_q, found_q, landed_q, n_q;
  logic [KEY_W-1:0]      cur_key_q;
  logic [COUNT_BITS-1:0] cur_cnt_q;
  logic [ENT_W-1:0]      d_q;
  logic                  placed_q;
  logic [CAPACITY-1:0]   occ_q;
  logic [ENT_W-1:0]      ent_q;
  logic [LIMIT_W-1:0]    limit_q;
  logic                  done_q, edge_q;
  logic [STATUS_W-1:0]   status_q;
  logic [SLOT_W-1:0]     slot_q;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [ROW_W-1:0]      ram_wdata, ram_rdata;
  logic [KEY_W-1:0]      rkey;
  logic [COUNT_BITS-1:0] rcnt;
  logic [SLOT_W-1:0]     rdist;
  logic                  swap;

  rrht_ram #(
    .Width(ROW_W),
    .Depth(CAPACITY)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(probe_q),
    .rdata_o(ram_rdata)
  );

  assign rkey  = ram_rdata[ROW_W-1:COUNT_BITS];
  assign rcnt  = ram_rdata[COUNT_BITS-1:0];
  assign rdist = probe_q - rkey[SLOT_W-1:0];
  // A resident entry closer to its home than the arriving one gives way.
  assign swap  = ({1'b0, rdist} < d_q);

  assign sts_o.kind      = kind_q;
  assign sts_o.occ       = occ_q[probe_q];
  assign sts_o.key_eq    = (rkey == key_q);
  assign sts_o.dist0     = (rdist == '0);
  assign sts_o.find_last = (n_q == SLOT_W'(CAPACITY - 1));
  assign sts_o.rem_last  = (n_q == SLOT_W'(CAPACITY - 2));
  assign sts_o.room      = ((LIMIT_W + 1)'(ent_q) + (LIMIT_W + 1)'(1) <
                            (LIMIT_W + 1)'(limit_q)) &&
                           (ent_q < ENT_W'(CAPACITY));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = probe_q;
    ram_wdata = {cur_key_q, cur_cnt_q};
    case (cmd_i)
      CMD_FOUND: begin
        if (kind_q == KIND_LOAD && rcnt != COUNT_MAX) begin
          ram_we    = 1'b1;
          ram_wdata = {rkey, rcnt + COUNT_BITS'(1)};
        end else if (kind_q == KIND_UNLOAD && rcnt != '0) begin
          ram_we    = 1'b1;
          ram_wdata = {rkey, rcnt - COUNT_BITS'(1)};
        end
      end
      CMD_INS_STEP:  ram_we = swap;
      CMD_INS_PLACE: ram_we = 1'b1;
      CMD_REM_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = hole_q;
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  // Working registers; none of them needs a reset value.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_START: begin
        kind_q  <= kind_i;
        key_q   <= key_i;
        probe_q <= key_i[SLOT_W-1:0];
        n_q     <= '0;
      end
      CMD_FIND_NEXT: begin
        probe_q <= probe_q + SLOT_W'(1);
        n_q     <= n_q + SLOT_W'(1);
      end
      CMD_INS_BEGIN: begin
        probe_q   <= key_q[SLOT_W-1:0];
        cur_key_q <= key_q;
        cur_cnt_q <= COUNT_BITS'(1);
        placed_q  <= 1'b0;
        // First probe is at distance zero.
        d_q       <= '0;
      end
      CMD_INS_STEP: begin
        if (swap) begin
          cur_key_q <= rkey;
          cur_cnt_q <= rcnt;
          d_q       <= {1'b0, rdist} + ENT_W'(1);
          if (!placed_q) begin
            landed_q <= probe_q;
            placed_q <= 1'b1;
          end
        end else begin
          d_q <= d_q + ENT_W'(1);
        end
        probe_q <= probe_q + SLOT_W'(1);
      end
      CMD_REM_BEGIN: begin
        found_q <= probe_q;
        hole_q  <= probe_q;
        probe_q <= probe_q + SLOT_W'(1);
        n_q     <= '0;
      end
      CMD_REM_SHIFT: begin
        hole_q  <= probe_q;
        probe_q <= probe_q + SLOT_W'(1);
        n_q     <= n_q + SLOT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      ent_q    <= '0;
      limit_q  <= LIMIT_RESET;
      done_q   <= 1'b0;
      status_q <= ST_DONE;
      slot_q   <= '0;
      edge_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      case (cmd_i)
        CMD_FOUND: begin
          done_q   <= 1'b1;
          status_q <= ST_DONE;
          slot_q   <= probe_q;
          edge_q   <= 1'b0;
          if (kind_q == KIND_LOAD) begin
            if (rcnt == COUNT_MAX) begin
              status_q <= ST_SAT;
              slot_q   <= '0;
            end else begin
              edge_q <= (rcnt == '0);
            end
          end else if (rcnt == '0) begin
            status_q <= ST_ABSENT;
            slot_q   <= '0;
          end else if (kind_q == KIND_UNLOAD) begin
            edge_q <= (rcnt == COUNT_BITS'(1));
          end
        end
        CMD_MISS: begin
          done_q   <= 1'b1;
          status_q <= (kind_q == KIND_LOAD) ? ST_FULL : ST_ABSENT;
          slot_q   <= '0;
          edge_q   <= 1'b0;
        end
        CMD_INS_PLACE: begin
          occ_q[probe_q] <= 1'b1;
          ent_q          <= ent_q + ENT_W'(1);
          done_q         <= 1'b1;
          status_q       <= ST_DONE;
          slot_q         <= placed_q ? landed_q : probe_q;
          edge_q         <= 1'b1;
        end
        CMD_REM_END: begin
          occ_q[hole_q] <= 1'b0;
          if (ent_q != '0) begin
            ent_q <= ent_q - ENT_W'(1);
          end
          done_q   <= 1'b1;
          status_q <= ST_DONE;
          slot_q   <= found_q;
          edge_q   <= 1'b0;
        end
        CMD_MISC: begin
          done_q <= 1'b1;
          slot_q <= '0;
          edge_q <= 1'b0;
          if (kind_q == KIND_CLEAR) begin
            occ_q    <= '0;
            ent_q    <= '0;
            status_q <= ST_DONE;
          end else begin
            status_q <= ST_ABSENT;
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign slot_o     = slot_q;
  assign edge_res_o = edge_q;
  assign entries_o  = ent_q;

endmodule
`default_nettype wire

/* rtl/refcounted_robin_hood_table.sv */
// Reference-counted Robin Hood hash table of 32-bit ids, 256 slots.
// Commands: raise start with kind_i and key_i; the command is taken at a
// clock edge where start is high and busy is low. busy stays high
// while the command is worked on.
// Each command gives exactly one result: done_o is high for one cycle with
// status_o, slot_o, edge_res_o and entries_o valid. The result cannot be
// held off; the receiver must take it in that cycle.
// Probing: every probe of a slot reads the slot memory (registered read)
// and then checks it. A hit at the home slot returns done_o after that
// first probe; each further probe adds another read and check. A new id
// is then placed by a second walk from its home slot, one read and check
// per slot up to the free one; a removal reads and checks the following
// slots, shifting each entry back by one, until a free slot, an entry in
// its home slot or a full lap ends it. Clear and unknown kinds do not probe.
// A new command may be taken in the cycle where done_o is high.
// occupancy_limit is written over the cfg channel (cfg_ready_o always high);
// the user must do so only with no command in flight; it is not enforced.
// Reset empties the table, zeroes the entry count and sets the limit to 128.
`default_nettype none
module refcounted_robin_hood_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [rrht_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [rrht_pkg::KEY_W-1:0]    key_i,
  output      logic                          done_o,
  output      logic [rrht_pkg::STATUS_W-1:0] status_o,
  output      logic [rrht_pkg::SLOT_W-1:0]   slot_o,
  output      logic                          edge_res_o,
  output      logic [rrht_pkg::ENT_W-1:0]    entries_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [rrht_pkg::LIMIT_W-1:0]  cfg_data_i
);
  import rrht_pkg::*;

  logic [CMD_W-1:0] cmd;
  sts_t             sts;

  assign cfg_ready_o = 1'b1;

  rrht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .kind_i (kind_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  rrht_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .kind_i     (kind_i),
    .key_i      (key_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .sts_o      (sts),
    .done_o     (done_o),
    .status_o   (status_o),
    .slot_o     (slot_o),
    .edge_res_o (edge_res_o),
    .entries_o  (entries_o)
  );

endmodule
`default_nettype wire
